// ===== design/ipt_pkg.sv =====
// Shared types, codes and constants for the interpolated potential table lookup.
package ipt_pkg;

   localparam int MAX_KINDS_DEF        = 4;
   localparam int TABLE_DEPTH_DEF      = 512;
   localparam int VALUE_WIDTH_DEF      = 32;
   localparam int RADIUS_FRAC_BITS_DEF = 16;

   localparam int KIND_W      = 2;
   localparam int RADIUS_W    = 24;
   localparam int ENTRY_IDX_W = 9;
   localparam int CUTOFF_W    = 24;
   localparam int STEP_W      = 32;
   localparam int LEN_W       = 10;
   localparam int KCOUNT_W    = 3;
   localparam int KC_CMP_W    = 5;
   localparam int FRAC_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CUTOFF_W-1:0] CUTOFF_RST = '0;
   localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(65536);
   localparam logic [LEN_W-1:0]    LEN_RST    = LEN_W'(512);
   localparam logic [KCOUNT_W-1:0] KCOUNT_RST = KCOUNT_W'(4);

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic {
      MODE_PER_KIND = 1'b0,
      MODE_PER_PAIR = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_BAD_SEL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUTOFF = 3'd0,
      CSR_STEP   = 3'd1,
      CSR_LENGTH = 3'd2,
      CSR_KCOUNT = 3'd3,
      CSR_MODE   = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic       live;
      status_type status;
   } ctl_type;

endpackage

// ===== design/ipt_ifs.sv =====
// Request and response channel interfaces for the table lookup.
interface ipt_req_if #(
   parameter int VALUE_WIDTH = ipt_pkg::VALUE_WIDTH_DEF
);
   logic                               valid;
   logic                               ready;
   ipt_pkg::op_type                    operation;
   logic                               quantity;
   logic [ipt_pkg::KIND_W-1:0]         first_kind;
   logic [ipt_pkg::KIND_W-1:0]         second_kind;
   logic [ipt_pkg::RADIUS_W-1:0]       radius;
   logic [ipt_pkg::ENTRY_IDX_W-1:0]    entry_index;
   logic signed [VALUE_WIDTH-1:0]      entry_value;

   modport source (output valid, operation, quantity, first_kind, second_kind, radius,
                   entry_index, entry_value, input ready);
   modport sink   (input valid, operation, quantity, first_kind, second_kind, radius,
                   entry_index, entry_value, output ready);
endinterface

interface ipt_rsp_if #(
   parameter int VALUE_WIDTH = ipt_pkg::VALUE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   ipt_pkg::status_type           status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

// ===== design/ipt_interp.sv =====
// Interpolation datapath: difference, partial products, rounding and output register.
module ipt_interp #(
   parameter int VALUE_WIDTH = ipt_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  ipt_pkg::ctl_type                    in_ctl,
   input  logic signed [VALUE_WIDTH-1:0]       in_bef,
   input  logic signed [VALUE_WIDTH-1:0]       in_aft,
   input  logic [ipt_pkg::FRAC_W-1:0]          in_frac,
   output ipt_pkg::ctl_type                    out_ctl,
   output logic signed [VALUE_WIDTH-1:0]       out_value
);
   localparam int HI_W = (VALUE_WIDTH > 16) ? VALUE_WIDTH - 16 : 1;
   localparam int LO_PROD_W = 2 * ipt_pkg::FRAC_W;

   ipt_pkg::ctl_type                   s4_ctl_ff, s5_ctl_ff, out_ctl_ff;
   logic [VALUE_WIDTH-1:0]             s4_mag_ff;
   logic                               s4_rise_ff, s5_rise_ff;
   logic signed [VALUE_WIDTH-1:0]      s4_bef_ff, s5_bef_ff;
   logic [ipt_pkg::FRAC_W-1:0]         s4_frac_ff;
   logic [VALUE_WIDTH-1:0]             s5_hi_prod_ff;
   logic [LO_PROD_W-1:0]               s5_lo_prod_ff;
   logic signed [VALUE_WIDTH-1:0]      out_value_ff;

   logic                               rise_in;
   logic [VALUE_WIDTH-1:0]             mag_in;
   logic [HI_W-1:0]                    mag_hi;
   logic [HI_W+15:0]                   hi_full;
   logic [VALUE_WIDTH-1:0]             hi_prod_in;
   logic [LO_PROD_W-1:0]               lo_prod_in;
   logic [ipt_pkg::FRAC_W-1:0]         rnd;
   logic [LO_PROD_W:0]                 lo_sum;
   logic [VALUE_WIDTH:0]               delta;
   logic signed [VALUE_WIDTH-1:0]      res;
   logic signed [VALUE_WIDTH-1:0]      out_value_in;

   always_comb begin
      rise_in = (in_aft >= in_bef);
      mag_in  = rise_in ? VALUE_WIDTH'(in_aft - in_bef) : VALUE_WIDTH'(in_bef - in_aft);
   end

   always_comb begin
      mag_hi     = HI_W'(s4_mag_ff >> 16);
      hi_full    = (HI_W+16)'(mag_hi) * (HI_W+16)'(s4_frac_ff);
      hi_prod_in = VALUE_WIDTH'(hi_full);
      lo_prod_in = LO_PROD_W'(s4_mag_ff[15:0]) * LO_PROD_W'(s4_frac_ff);
   end

   always_comb begin
      rnd    = s5_rise_ff ? 16'h8000 : 16'h7FFF;
      lo_sum = (LO_PROD_W+1)'(s5_lo_prod_ff) + (LO_PROD_W+1)'(rnd);
      delta  = (VALUE_WIDTH+1)'(s5_hi_prod_ff) + (VALUE_WIDTH+1)'(lo_sum[LO_PROD_W:16]);
      if (s5_rise_ff) begin
         res = s5_bef_ff + $signed(delta[VALUE_WIDTH-1:0]);
      end else begin
         res = s5_bef_ff - $signed(delta[VALUE_WIDTH-1:0]);
      end
      out_value_in = (s5_ctl_ff.status == ipt_pkg::STATUS_OK) ? res : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff  <= '0;
         s5_ctl_ff  <= '0;
         out_ctl_ff <= '0;
      end else if (advance) begin
         s4_ctl_ff  <= in_ctl;
         s5_ctl_ff  <= s4_ctl_ff;
         out_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_mag_ff     <= mag_in;
         s4_rise_ff    <= rise_in;
         s4_bef_ff     <= in_bef;
         s4_frac_ff    <= in_frac;
         s5_hi_prod_ff <= hi_prod_in;
         s5_lo_prod_ff <= lo_prod_in;
         s5_rise_ff    <= s4_rise_ff;
         s5_bef_ff     <= s4_bef_ff;
         out_value_ff  <= out_value_in;
      end
   end

   assign out_ctl   = out_ctl_ff;
   assign out_value = out_value_ff;

endmodule

// ===== design/interpolated_potential_table_lookup_top.sv =====
// Top level of the interpolated potential table lookup.
// A lookup result passes the s1, s2 and s3 registers, then s4, s5 and the output register, before it is valid.
// Throughput: one item per cycle; ready drops only while a result waits at the output.
// Both neighbor entries come from the two read ports of the table memory in the same cycle.
// Reset clears the pipeline and loads the register defaults; the table memory is not
// cleared and holds undefined data until written.
module interpolated_potential_table_lookup_top #(
   parameter int MAX_KINDS        = ipt_pkg::MAX_KINDS_DEF,
   parameter int TABLE_DEPTH      = ipt_pkg::TABLE_DEPTH_DEF,
   parameter int VALUE_WIDTH      = ipt_pkg::VALUE_WIDTH_DEF,
   parameter int RADIUS_FRAC_BITS = ipt_pkg::RADIUS_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ipt_req_if.sink                           req_ch,
   ipt_rsp_if.source                         rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [ipt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ipt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int TAB_PER_Q   = MAX_KINDS * MAX_KINDS;
   localparam int TAB_COUNT   = 2 * TAB_PER_Q;
   localparam int TAB_W       = $clog2(TAB_COUNT);
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int STORE_DEPTH = TAB_COUNT * TABLE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PROD_W      = ipt_pkg::RADIUS_W + 16;
   localparam int SCALED_W    = ipt_pkg::RADIUS_W + ipt_pkg::STEP_W;
   localparam int IB_W        = SCALED_W - RADIUS_FRAC_BITS - 16;
   localparam int KC_W        = ipt_pkg::KC_CMP_W;

   // configuration
   logic [ipt_pkg::CUTOFF_W-1:0]  cutoff_ff;
   logic [ipt_pkg::STEP_W-1:0]    step_ff;
   logic [ipt_pkg::LEN_W-1:0]     length_ff;
   logic [ipt_pkg::KCOUNT_W-1:0]  kcount_ff;
   ipt_pkg::mode_type             mode_ff;

   logic advance;
   logic accept;
   ipt_pkg::ctl_type out_ctl;

   // stage 1
   logic                          s1_live_ff;
   ipt_pkg::op_type               s1_op_ff;
   logic [TAB_W-1:0]              s1_tab_ff;
   logic                          s1_sel_ok_ff, s1_beyond_ff, s1_widx_ok_ff;
   logic [IDX_W-1:0]              s1_idx_ff;
   logic signed [VALUE_WIDTH-1:0] s1_wval_ff;
   logic [PROD_W-1:0]             s1_prod_lo_ff, s1_prod_hi_ff;

   // stage 2
   logic                          s2_live_ff;
   ipt_pkg::op_type               s2_op_ff;
   logic [TAB_W-1:0]              s2_tab_ff;
   logic                          s2_sel_ok_ff, s2_beyond_ff, s2_widx_ok_ff;
   logic [IDX_W-1:0]              s2_idx_ff;
   logic signed [VALUE_WIDTH-1:0] s2_wval_ff;
   logic [SCALED_W-1:0]           s2_scaled_ff;

   // stage 3
   ipt_pkg::ctl_type              s3_ctl_ff;
   logic [ipt_pkg::FRAC_W-1:0]    s3_frac_ff;
   logic signed [VALUE_WIDTH-1:0] s3_bef_ff, s3_aft_ff;

   logic signed [VALUE_WIDTH-1:0] store_mem [STORE_DEPTH];

   // stage 0 logic
   logic [KC_W-1:0]               kc;
   logic [KC_W-1:0]               a_ext, b_ext;
   logic [2*KC_W-1:0]             pair_tab;
   logic                          sel_ok_in;
   logic [TAB_W-1:0]              tab_in, tab_sel_in;
   logic                          beyond_in, widx_ok_in;
   logic [PROD_W-1:0]             prod_lo_in, prod_hi_in;
   logic [SCALED_W-1:0]           scaled_in;

   // stage 2 logic
   logic [ipt_pkg::LEN_W-1:0]     len_use;
   logic [IB_W-1:0]               ib;
   logic [IDX_W-1:0]              ib_idx, ib_next;
   logic                          end_in;
   logic [ADDR_W-1:0]             base, wr_addr, rd_addr_a, rd_addr_b;
   logic                          wr_en;
   ipt_pkg::ctl_type              s3_ctl_in;

   assign advance      = !out_ctl.live || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= ipt_pkg::CUTOFF_RST;
         step_ff   <= ipt_pkg::STEP_RST;
         length_ff <= ipt_pkg::LEN_RST;
         kcount_ff <= ipt_pkg::KCOUNT_RST;
         mode_ff   <= ipt_pkg::MODE_PER_PAIR;
      end else if (csr_wr_en) begin
         case (ipt_pkg::csr_reg_type'(csr_index))
            ipt_pkg::CSR_CUTOFF: cutoff_ff <= csr_wdata[ipt_pkg::CUTOFF_W-1:0];
            ipt_pkg::CSR_STEP:   step_ff   <= csr_wdata[ipt_pkg::STEP_W-1:0];
            ipt_pkg::CSR_LENGTH: length_ff <= csr_wdata[ipt_pkg::LEN_W-1:0];
            ipt_pkg::CSR_KCOUNT: kcount_ff <= csr_wdata[ipt_pkg::KCOUNT_W-1:0];
            ipt_pkg::CSR_MODE:   mode_ff   <= ipt_pkg::mode_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   // table selection, cutoff and radius scaling partial products
   always_comb begin
      kc = (KC_W'(kcount_ff) > KC_W'(MAX_KINDS)) ? KC_W'(MAX_KINDS) : KC_W'(kcount_ff);
      a_ext    = KC_W'(req_ch.first_kind);
      b_ext    = KC_W'(req_ch.second_kind);
      pair_tab = (2*KC_W)'(a_ext) + (2*KC_W)'(kc) * (2*KC_W)'(b_ext);
      if (mode_ff == ipt_pkg::MODE_PER_KIND) begin
         sel_ok_in = (b_ext != '0) && (b_ext <= kc);
         tab_in    = TAB_W'(b_ext - KC_W'(1));
      end else begin
         sel_ok_in = (a_ext < kc) && (b_ext < kc);
         tab_in    = TAB_W'(pair_tab);
      end
      tab_sel_in = req_ch.quantity ? TAB_W'(TAB_PER_Q) + tab_in : tab_in;
      beyond_in  = (req_ch.radius >= cutoff_ff);
      widx_ok_in = (32'(req_ch.entry_index) < 32'(TABLE_DEPTH));
      prod_lo_in = PROD_W'(req_ch.radius) * PROD_W'(step_ff[15:0]);
      prod_hi_in = PROD_W'(req_ch.radius) * PROD_W'(step_ff[31:16]);
   end

   assign scaled_in = SCALED_W'(s1_prod_lo_ff) + {s1_prod_hi_ff, 16'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_live_ff <= 1'b0;
         s2_live_ff <= 1'b0;
         s3_ctl_ff  <= '0;
      end else if (advance) begin
         s1_live_ff <= accept;
         s2_live_ff <= s1_live_ff;
         s3_ctl_ff  <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff       <= req_ch.operation;
         s1_tab_ff      <= tab_sel_in;
         s1_sel_ok_ff   <= sel_ok_in;
         s1_beyond_ff   <= beyond_in;
         s1_widx_ok_ff  <= widx_ok_in;
         s1_idx_ff      <= IDX_W'(req_ch.entry_index);
         s1_wval_ff     <= req_ch.entry_value;
         s1_prod_lo_ff  <= prod_lo_in;
         s1_prod_hi_ff  <= prod_hi_in;
         s2_op_ff       <= s1_op_ff;
         s2_tab_ff      <= s1_tab_ff;
         s2_sel_ok_ff   <= s1_sel_ok_ff;
         s2_beyond_ff   <= s1_beyond_ff;
         s2_widx_ok_ff  <= s1_widx_ok_ff;
         s2_idx_ff      <= s1_idx_ff;
         s2_wval_ff     <= s1_wval_ff;
         s2_scaled_ff   <= scaled_in;
         s3_frac_ff     <= s2_scaled_ff[RADIUS_FRAC_BITS+15 -: 16];
      end
   end

   // entry before, table end check and memory addresses
   always_comb begin
      len_use = (32'(length_ff) > 32'(TABLE_DEPTH)) ? ipt_pkg::LEN_W'(TABLE_DEPTH) : length_ff;
      ib      = s2_scaled_ff[SCALED_W-1 -: IB_W];
      ib_idx  = ib[IDX_W-1:0];
      ib_next = ib_idx + IDX_W'(1);
      end_in  = ((IB_W+1)'(ib) + (IB_W+1)'(1)) >= (IB_W+1)'(len_use);
      base      = ADDR_W'(s2_tab_ff) * ADDR_W'(TABLE_DEPTH);
      wr_addr   = base + ADDR_W'(s2_idx_ff);
      rd_addr_a = base + ADDR_W'(ib_idx);
      rd_addr_b = base + ADDR_W'(ib_next);
      wr_en     = advance && s2_live_ff && (s2_op_ff == ipt_pkg::OP_WRITE) &&
                  s2_sel_ok_ff && s2_widx_ok_ff;
      s3_ctl_in.live = s2_live_ff && (s2_op_ff == ipt_pkg::OP_LOOKUP);
      if (!s2_sel_ok_ff) begin
         s3_ctl_in.status = ipt_pkg::STATUS_BAD_SEL;
      end else if (s2_beyond_ff || end_in) begin
         s3_ctl_in.status = ipt_pkg::STATUS_RANGE;
      end else begin
         s3_ctl_in.status = ipt_pkg::STATUS_OK;
      end
   end

   // writes and reads share one stage, so item order is kept without forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= s2_wval_ff;
      end
      if (advance) begin
         s3_bef_ff <= store_mem[rd_addr_a];
         s3_aft_ff <= store_mem[rd_addr_b];
      end
   end

   ipt_interp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ipt_interp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (s3_ctl_ff),
      .in_bef    (s3_bef_ff),
      .in_aft    (s3_aft_ff),
      .in_frac   (s3_frac_ff),
      .out_ctl   (out_ctl),
      .out_value (rsp_ch.value)
   );

   assign rsp_ch.valid  = out_ctl.live;
   assign rsp_ch.status = out_ctl.status;

endmodule

// ===== design/ipt_checker.sv =====
// Port-level checks for the table lookup top level, attached by bind.
module ipt_checker #(
   parameter int VALUE_WIDTH = ipt_pkg::VALUE_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_value,
   input logic [1:0]             rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("stalled response item changed or dropped");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ipt_pkg::STATUS_OK) |-> (rsp_value == '0))
      else $error("failed lookup carries a nonzero value");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no response pending");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind interpolated_potential_table_lookup_top ipt_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_ipt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_value  (rsp_ch.value),
   .rsp_status (rsp_ch.status)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the interpolated potential table lookup.
`timescale 1ns / 100ps

module testbench;

   localparam int STORE_DEPTH = 2 * ipt_pkg::MAX_KINDS_DEF * ipt_pkg::MAX_KINDS_DEF *
                                ipt_pkg::TABLE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      ipt_pkg::op_type                            operation;
      logic                                       quantity;
      logic [ipt_pkg::KIND_W-1:0]                 first_kind;
      logic [ipt_pkg::KIND_W-1:0]                 second_kind;
      logic [ipt_pkg::RADIUS_W-1:0]               radius;
      logic [ipt_pkg::ENTRY_IDX_W-1:0]            entry_index;
      logic signed [ipt_pkg::VALUE_WIDTH_DEF-1:0] entry_value;
   } lookup_req_type;

   typedef struct packed {
      logic signed [ipt_pkg::VALUE_WIDTH_DEF-1:0] value;
      ipt_pkg::status_type                        status;
   } lookup_rsp_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [ipt_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ipt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   ipt_req_if req_ch ();
   ipt_rsp_if rsp_ch ();

   interpolated_potential_table_lookup_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadows, updated once a full register set has been written
   logic [ipt_pkg::CUTOFF_W-1:0] cutoff_cfg = ipt_pkg::CUTOFF_RST;
   logic [ipt_pkg::STEP_W-1:0]   step_cfg   = ipt_pkg::STEP_RST;
   logic [ipt_pkg::LEN_W-1:0]    length_cfg = ipt_pkg::LEN_RST;
   logic [ipt_pkg::KCOUNT_W-1:0] kinds_cfg  = ipt_pkg::KCOUNT_RST;
   ipt_pkg::mode_type            mode_cfg   = ipt_pkg::MODE_PER_PAIR;

   logic signed [ipt_pkg::VALUE_WIDTH_DEF-1:0] table_mem [STORE_DEPTH];
   bit                                         entry_loaded [STORE_DEPTH];

   lookup_req_type request_queue [$];
   lookup_rsp_type awaited_answers [$];
   lookup_req_type driven_request;
   lookup_rsp_type oldest_answer;

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned fail_count     = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned slot(logic q, int unsigned tab, int unsigned pos);
      return ((q ? ipt_pkg::MAX_KINDS_DEF * ipt_pkg::MAX_KINDS_DEF : 0) + tab) *
             ipt_pkg::TABLE_DEPTH_DEF + pos;
   endfunction

   // table selection and entry position under the current registers
   function automatic ipt_pkg::status_type locate(lookup_req_type r,
                                                  output int unsigned tab,
                                                  output int unsigned pos,
                                                  output logic [15:0] frac);
      int unsigned kinds;
      int unsigned span;
      logic [63:0] scaled;
      kinds = (kinds_cfg > ipt_pkg::MAX_KINDS_DEF) ? ipt_pkg::MAX_KINDS_DEF : kinds_cfg;
      span  = (length_cfg > ipt_pkg::TABLE_DEPTH_DEF) ? ipt_pkg::TABLE_DEPTH_DEF : length_cfg;
      tab   = 0;
      pos   = 32'(r.entry_index);
      frac  = '0;
      if (mode_cfg == ipt_pkg::MODE_PER_KIND) begin
         if (r.second_kind == 0 || r.second_kind > kinds) return ipt_pkg::STATUS_BAD_SEL;
         tab = r.second_kind - 1;
      end else begin
         if (r.first_kind >= kinds || r.second_kind >= kinds) return ipt_pkg::STATUS_BAD_SEL;
         tab = r.first_kind + kinds * r.second_kind;
      end
      if (r.operation == ipt_pkg::OP_WRITE) return ipt_pkg::STATUS_OK;
      if (r.radius >= cutoff_cfg) return ipt_pkg::STATUS_RANGE;
      scaled = 64'(r.radius) * 64'(step_cfg);
      pos    = scaled[63:32];
      frac   = scaled[31:16];
      if (64'(pos) + 1 >= 64'(span)) return ipt_pkg::STATUS_RANGE;
      return ipt_pkg::STATUS_OK;
   endfunction

   function automatic void table_answer(lookup_req_type r);
      int unsigned tab;
      int unsigned pos;
      logic [15:0] frac;
      ipt_pkg::status_type st;
      lookup_rsp_type ans;
      logic signed [63:0] lo_e;
      logic signed [63:0] hi_e;
      logic [63:0] mag;
      logic [63:0] delta;
      st = locate(r, tab, pos, frac);
      if (r.operation == ipt_pkg::OP_WRITE) begin
         if (st == ipt_pkg::STATUS_OK) table_mem[slot(r.quantity, tab, pos)] = r.entry_value;
         return;
      end
      ans.value  = '0;
      ans.status = st;
      if (st == ipt_pkg::STATUS_OK) begin
         lo_e = 64'(table_mem[slot(r.quantity, tab, pos)]);
         hi_e = 64'(table_mem[slot(r.quantity, tab, pos + 1)]);
         // round half toward plus infinity in both directions
         if (hi_e >= lo_e) begin
            mag       = hi_e - lo_e;
            delta     = (mag >> 16) * frac + (((mag & 64'hFFFF) * frac + 64'h8000) >> 16);
            ans.value = ipt_pkg::VALUE_WIDTH_DEF'(lo_e + delta);
         end else begin
            mag       = lo_e - hi_e;
            delta     = (mag >> 16) * frac + (((mag & 64'hFFFF) * frac + 64'h7FFF) >> 16);
            ans.value = ipt_pkg::VALUE_WIDTH_DEF'(lo_e - delta);
         end
      end
      awaited_answers = {awaited_answers, ans};
   endfunction

   // queues an item; a lookup that reads unloaded entries gets writes first
   function automatic void queue_request(lookup_req_type r);
      int unsigned tab;
      int unsigned pos;
      logic [15:0] frac;
      ipt_pkg::status_type st;
      lookup_req_type fill;
      st = locate(r, tab, pos, frac);
      if (r.operation == ipt_pkg::OP_LOOKUP && st == ipt_pkg::STATUS_OK) begin
         for (int e = 0; e < 2; e++) begin
            if (!entry_loaded[slot(r.quantity, tab, pos + e)]) begin
               fill             = r;
               fill.operation   = ipt_pkg::OP_WRITE;
               fill.entry_index = ipt_pkg::ENTRY_IDX_W'(pos + e);
               fill.entry_value = $urandom;
               entry_loaded[slot(r.quantity, tab, pos + e)] = 1'b1;
               request_queue = {request_queue, fill};
               queued_count++;
            end
         end
      end else if (r.operation == ipt_pkg::OP_WRITE && st == ipt_pkg::STATUS_OK) begin
         entry_loaded[slot(r.quantity, tab, pos)] = 1'b1;
      end
      request_queue = {request_queue, r};
      queued_count++;
   endfunction

   function automatic lookup_req_type make_request(ipt_pkg::op_type op, logic q,
                                                   logic [1:0] a, logic [1:0] b,
                                                   logic [23:0] rad, logic [8:0] idx,
                                                   logic [31:0] val);
      lookup_req_type r;
      r.operation   = op;
      r.quantity    = q;
      r.first_kind  = a;
      r.second_kind = b;
      r.radius      = rad;
      r.entry_index = idx;
      r.entry_value = val;
      return r;
   endfunction

   function automatic lookup_req_type random_request();
      return make_request(ipt_pkg::op_type'($urandom_range(1)), 1'($urandom_range(1)),
                          2'($urandom_range(3)), 2'($urandom_range(3)),
                          24'($urandom_range(24'hFFFFFF)), 9'($urandom_range(511)),
                          $urandom);
   endfunction

   task automatic csr_write(ipt_pkg::csr_reg_type idx, logic [ipt_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_config(logic [ipt_pkg::CUTOFF_W-1:0] cutoff,
                              logic [ipt_pkg::STEP_W-1:0] step,
                              logic [ipt_pkg::LEN_W-1:0] len,
                              logic [ipt_pkg::KCOUNT_W-1:0] kinds,
                              ipt_pkg::mode_type mode);
      csr_write(ipt_pkg::CSR_CUTOFF, ipt_pkg::CSR_DATA_W'(cutoff));
      csr_write(ipt_pkg::CSR_STEP, step);
      csr_write(ipt_pkg::CSR_LENGTH, ipt_pkg::CSR_DATA_W'(len));
      csr_write(ipt_pkg::CSR_KCOUNT, ipt_pkg::CSR_DATA_W'(kinds));
      csr_write(ipt_pkg::CSR_MODE, ipt_pkg::CSR_DATA_W'(mode));
      csr_wr_en  <= 1'b0;
      cutoff_cfg = cutoff;
      step_cfg   = step;
      length_cfg = len;
      kinds_cfg  = kinds;
      mode_cfg   = mode;
   endtask

   // lets every item through and the pipeline empty out
   task automatic drain();
      while (accepted_count != queued_count || awaited_answers.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            table_answer(driven_request);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_request      = request_queue.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.operation   <= driven_request.operation;
               req_ch.quantity    <= driven_request.quantity;
               req_ch.first_kind  <= driven_request.first_kind;
               req_ch.second_kind <= driven_request.second_kind;
               req_ch.radius      <= driven_request.radius;
               req_ch.entry_index <= driven_request.entry_index;
               req_ch.entry_value <= driven_request.entry_value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_answers.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, actual value %h status %0d",
                        $time, rsp_ch.value, rsp_ch.status);
            end else begin
               oldest_answer = awaited_answers.pop_front();
               if (rsp_ch.value !== oldest_answer.value) begin
                  fail_count++;
                  $display("%0t: value mismatch: expected %h, actual %h",
                           $time, oldest_answer.value, rsp_ch.value);
               end
               if (rsp_ch.status !== oldest_answer.status) begin
                  fail_count++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, oldest_answer.status, rsp_ch.status);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      lookup_req_type r;
      int unsigned kinds;
      int unsigned span;
      int unsigned count;
      logic [63:0] target;
      req_ch.valid       = 1'b0;
      req_ch.operation   = ipt_pkg::OP_WRITE;
      req_ch.quantity    = 1'b0;
      req_ch.first_kind  = '0;
      req_ch.second_kind = '0;
      req_ch.radius      = '0;
      req_ch.entry_index = '0;
      req_ch.entry_value = '0;
      rsp_ch.ready       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 81;
      load_config(24'hFFFFFF, 32'h0002_0000, 10'd512, 3'd3, ipt_pkg::MODE_PER_PAIR);
      // extreme entries, rising and falling spans, table end, bad selections, ties
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b0, 2'd1, 2'd2, 24'h0, 9'd0, 32'h7FFFFFFF));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b0, 2'd1, 2'd2, 24'h0, 9'd1, 32'h80000000));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b0, 2'd1, 2'd2, 24'h0, 9'd510,
                                 32'h80000000));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b0, 2'd1, 2'd2, 24'h0, 9'd511,
                                 32'h7FFFFFFF));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b1, 2'd2, 2'd2, 24'h0, 9'd0, 32'h00012345));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b1, 2'd2, 2'd2, 24'h0, 9'd1, 32'h00012345));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b0, 2'd3, 2'd0, 24'h0, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd1, 2'd2, 24'h000000, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd1, 2'd2, 24'h004000, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd1, 2'd2, 24'h007FFF, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd1, 2'd2, 24'hFF0000, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd1, 2'd2, 24'hFF7FFF, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd1, 2'd2, 24'hFFFFFF, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b1, 2'd2, 2'd2, 24'h004000, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd3, 2'd0, 24'h001000, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b0, 2'd0, 2'd3, 24'h001000, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b1, 2'd0, 2'd0, 24'h000000, 9'h1FF,
                                 32'hFFFFFFFF));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b1, 2'd0, 2'd1, 24'h0, 9'd0, 32'd1));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b1, 2'd0, 2'd1, 24'h0, 9'd1, 32'd0));
      queue_request(make_request(ipt_pkg::OP_WRITE, 1'b1, 2'd0, 2'd1, 24'h0, 9'd2, 32'd1));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b1, 2'd0, 2'd1, 24'h004000, 9'd0, 32'h0));
      queue_request(make_request(ipt_pkg::OP_LOOKUP, 1'b1, 2'd0, 2'd1, 24'h00C000, 9'd0, 32'h0));
      drain();

      for (int p = 0; p < 7; p++) begin
         send_idle_pct = (p < 2) ? 30 : (p < 4) ? 81 : 0;
         recv_idle_pct = (p < 2) ? 81 : (p < 4) ? 30 : 0;
         case (p)
            0: load_config(24'hFFFFFF, 32'h0001_0000, 10'd512, 3'd4, ipt_pkg::MODE_PER_PAIR);
            1: load_config(24'h800000, 32'h0000_0000, 10'd2, 3'd1, ipt_pkg::MODE_PER_KIND);
            2: load_config(24'h000000, 32'h0000_0001, 10'd0, 3'd7, ipt_pkg::MODE_PER_PAIR);
            3: load_config(24'h123456, 32'hFFFF_FFFF, 10'd300, 3'd2, ipt_pkg::MODE_PER_KIND);
            4: load_config(24'hFFFFFF, 32'h0000_8000, 10'd1, 3'd0, ipt_pkg::MODE_PER_PAIR);
            5: load_config(24'hA00000, 32'h0001_8000, 10'd1023, 3'd4, ipt_pkg::MODE_PER_KIND);
            default: load_config(24'h7FFFFF, 32'h0002_3A5F, 10'd64, 3'd3, ipt_pkg::MODE_PER_PAIR);
         endcase
         kinds = (kinds_cfg > ipt_pkg::MAX_KINDS_DEF) ? ipt_pkg::MAX_KINDS_DEF : kinds_cfg;
         span  = (length_cfg > ipt_pkg::TABLE_DEPTH_DEF) ? ipt_pkg::TABLE_DEPTH_DEF
                                                         : length_cfg;
         count = (p == 2 || p == 4) ? 40 : 100;
         repeat (count) begin
            r = random_request();
            // mostly lookups into a valid table near loaded entries
            if ($urandom_range(99) < 75) begin
               r.operation = ipt_pkg::OP_LOOKUP;
               if (kinds != 0) begin
                  if (mode_cfg == ipt_pkg::MODE_PER_KIND) begin
                     r.second_kind = 2'($urandom_range(1, (kinds > 3) ? 3 : kinds));
                  end else begin
                     r.first_kind  = 2'($urandom_range(kinds - 1));
                     r.second_kind = 2'($urandom_range(kinds - 1));
                  end
               end
               case ($urandom_range(9))
                  0: r.radius = cutoff_cfg;
                  1: r.radius = cutoff_cfg - 24'd1;
                  default: begin
                     if (step_cfg != 0) begin
                        target = (64'($urandom_range((span >= 2) ? span - 2 : 0)) << 32)
                                 | 64'($urandom);
                        target = target / step_cfg;
                        r.radius = (target > 64'hFFFFFF) ? 24'hFFFFFF : target[23:0];
                     end
                  end
               endcase
            end
            queue_request(r);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ipt_pkg.sv
design/ipt_ifs.sv
design/ipt_interp.sv
design/interpolated_potential_table_lookup_top.sv
design/ipt_checker.sv
test/testbench.sv
